// ===== sv/pgcb_pkg.sv =====
// Shared types, constants and helper functions for the grid cell binning block.
package pgcb_pkg;

   localparam int COORD_FRAC_BITS = 4;
   localparam int REG_W           = 12;
   localparam int COORD_W         = 16;
   localparam int RADIUS_W        = 13;
   // wide enough for centre plus or minus radius and for the area limit in Q format
   localparam int CORNER_W        = ((COORD_W > REG_W + COORD_FRAC_BITS) ?
                                     COORD_W : REG_W + COORD_FRAC_BITS) + 2;
   localparam int CELL_W          = REG_W;
   localparam int STRIDE_W        = CELL_W + 1;
   localparam int PROD_W          = CELL_W + STRIDE_W;
   localparam int IDX_W           = 24;
   localparam int NUM_CORNERS     = 4;
   localparam int DIV_STEPS       = CELL_W;
   localparam int CSR_IDX_W       = 2;

   localparam int NUM_LANES = 5;
   localparam int LANE_LX   = 0;
   localparam int LANE_RX   = 1;
   localparam int LANE_TY   = 2;
   localparam int LANE_BY   = 3;
   localparam int LANE_COLS = 4;

   localparam int QDEPTH  = 32;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = QPTR_W + 1;

   localparam logic [1:0] CORNER_UL = 2'd0;
   localparam logic [1:0] CORNER_BR = 2'd1;
   localparam logic [1:0] CORNER_UR = 2'd2;
   localparam logic [1:0] CORNER_BL = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_AREA_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_SIZE   = 2'd2;

   localparam logic [REG_W-1:0] AREA_WIDTH_RST  = 12'd1024;
   localparam logic [REG_W-1:0] AREA_HEIGHT_RST = 12'd768;
   localparam logic [REG_W-1:0] CELL_SIZE_RST   = 12'd32;

   typedef struct packed {
      logic [REG_W-1:0] area_width;
      logic [REG_W-1:0] area_height;
      logic [REG_W-1:0] cell_size;   // never zero
   } pgcb_cfg_type;

   typedef struct packed {
      logic [NUM_CORNERS-1:0][IDX_W-1:0] idx;
      logic [1:0]                        last_corner;
   } pgcb_part_type;

   typedef struct packed {
      logic [CELL_W-1:0] rem;
      logic [CELL_W-1:0] nq;   // numerator bits still to enter, quotient bits shift in
   } pgcb_div_type;

   // Reduce a corner coordinate to a whole-pixel numerator; out-of-range
   // values clamp so that the division yields cell 0 or the last cell.
   function automatic logic [CELL_W-1:0] cell_numer(logic signed [CORNER_W-1:0] v,
                                                    logic [REG_W-1:0] extent);
      logic signed [CORNER_W-1:0] limit;
      logic [CELL_W-1:0]          n;
      limit = $signed(CORNER_W'(extent) << COORD_FRAC_BITS);
      if (v < 0)
         n = '0;
      else if (v > limit)
         n = extent;
      else
         n = v[COORD_FRAC_BITS +: CELL_W];
      return n;
   endfunction

   // One restoring division step: one quotient bit.
   function automatic pgcb_div_type div_step(pgcb_div_type s, logic [CELL_W-1:0] d);
      logic [CELL_W:0] t;
      logic [CELL_W:0] diff;
      pgcb_div_type    r;
      t    = {s.rem, s.nq[CELL_W-1]};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         r.rem = diff[CELL_W-1:0];
         r.nq  = {s.nq[CELL_W-2:0], 1'b1};
      end else begin
         r.rem = t[CELL_W-1:0];
         r.nq  = {s.nq[CELL_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ===== sv/pgcb_front.sv =====
// Front pipeline: corners, cell division lanes, bucket index and classification.
module pgcb_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pgcb_pkg::pgcb_cfg_type                 cfg,
   input  logic                                   in_valid,
   input  logic signed [pgcb_pkg::COORD_W-1:0]    in_center_x,
   input  logic signed [pgcb_pkg::COORD_W-1:0]    in_center_y,
   input  logic        [pgcb_pkg::RADIUS_W-1:0]   in_radius,
   output logic                                   out_valid,
   output pgcb_pkg::pgcb_part_type                out_part
);
   import pgcb_pkg::*;

   localparam int XLANE [NUM_CORNERS] = '{LANE_LX, LANE_RX, LANE_RX, LANE_LX};
   localparam int YLANE [NUM_CORNERS] = '{LANE_TY, LANE_BY, LANE_TY, LANE_BY};

   // capture stage
   logic                       a_valid_ff;
   logic signed [COORD_W-1:0]  a_cx_ff, a_cy_ff;
   logic [RADIUS_W-1:0]        a_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      a_cx_ff <= in_center_x;
      a_cy_ff <= in_center_y;
      a_r_ff  <= in_radius;
   end

   logic signed [CORNER_W-1:0] cx_w, cy_w, r_w, lx, rx, ty, by;
   logic [CELL_W-1:0]          numer [NUM_LANES];

   always_comb begin
      cx_w = CORNER_W'(a_cx_ff);
      cy_w = CORNER_W'(a_cy_ff);
      r_w  = $signed(CORNER_W'(a_r_ff));
      lx   = cx_w - r_w;
      rx   = cx_w + r_w;
      ty   = cy_w - r_w;
      by   = cy_w + r_w;
      numer[LANE_LX]   = cell_numer(lx, cfg.area_width);
      numer[LANE_RX]   = cell_numer(rx, cfg.area_width);
      numer[LANE_TY]   = cell_numer(ty, cfg.area_height);
      numer[LANE_BY]   = cell_numer(by, cfg.area_height);
      numer[LANE_COLS] = cfg.area_width;
   end

   // divider stages: stage 0 holds numerators, each later stage adds one bit
   logic [DIV_STEPS:0] dv_ff, dv_in;
   pgcb_div_type       div_ff [DIV_STEPS+1][NUM_LANES];
   pgcb_div_type       div_in [DIV_STEPS+1][NUM_LANES];

   always_comb begin
      dv_in[0] = a_valid_ff;
      for (int l = 0; l < NUM_LANES; l++) begin
         div_in[0][l].rem = '0;
         div_in[0][l].nq  = numer[l];
      end
      for (int s = 1; s <= DIV_STEPS; s++) begin
         dv_in[s] = dv_ff[s-1];
         for (int l = 0; l < NUM_LANES; l++)
            div_in[s][l] = div_step(div_ff[s-1][l], cfg.cell_size);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff <= '0;
      end else begin
         dv_ff <= dv_in;
      end
      div_ff <= div_in;
   end

   // stride multiply
   logic                m_valid_ff;
   logic [IDX_W-1:0]    m_prod_ff [NUM_CORNERS];
   logic [IDX_W-1:0]    m_prod_in [NUM_CORNERS];
   logic [CELL_W-1:0]   m_col_ff  [NUM_CORNERS];
   logic [CELL_W-1:0]   m_col_in  [NUM_CORNERS];
   logic [STRIDE_W-1:0] stride;
   logic [PROD_W-1:0]   prod      [NUM_CORNERS];

   always_comb begin
      stride = STRIDE_W'(div_ff[DIV_STEPS][LANE_COLS].nq) + STRIDE_W'(1);
      for (int k = 0; k < NUM_CORNERS; k++) begin
         prod[k] = PROD_W'(div_ff[DIV_STEPS][YLANE[k]].nq) * PROD_W'(stride);
         m_prod_in[k] = prod[k][IDX_W-1:0];
         m_col_in[k]  = div_ff[DIV_STEPS][XLANE[k]].nq;
      end
   end

   // index add
   logic             s_valid_ff;
   logic [IDX_W-1:0] s_idx_ff [NUM_CORNERS];
   logic [IDX_W-1:0] s_idx_in [NUM_CORNERS];

   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++)
         s_idx_in[k] = m_prod_ff[k] + IDX_W'(m_col_ff[k]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= dv_ff[DIV_STEPS];
         s_valid_ff <= m_valid_ff;
      end
      m_prod_ff <= m_prod_in;
      m_col_ff  <= m_col_in;
      s_idx_ff  <= s_idx_in;
   end

   // classify: one, two or four cells
   always_comb begin
      out_valid = s_valid_ff;
      for (int k = 0; k < NUM_CORNERS; k++)
         out_part.idx[k] = s_idx_ff[k];
      if (s_idx_ff[CORNER_UL] == s_idx_ff[CORNER_BR])
         out_part.last_corner = CORNER_UL;
      else if (s_idx_ff[CORNER_UL] != s_idx_ff[CORNER_BL] &&
               s_idx_ff[CORNER_UL] != s_idx_ff[CORNER_UR])
         out_part.last_corner = CORNER_BL;
      else
         out_part.last_corner = CORNER_BR;
   end

endmodule

// ===== sv/pgcb_queue.sv =====
// Particle queue between the front pipeline and the result serializer.
module pgcb_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  pgcb_pkg::pgcb_part_type push_part,
   input  logic                    pop,
   output logic                    not_empty,
   output pgcb_pkg::pgcb_part_type head_part
);
   import pgcb_pkg::*;

   pgcb_part_type     mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
      not_empty = count_ff != '0;
      head_part = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push)
         mem_ff[wr_ptr_ff] <= push_part;
   end

endmodule

// ===== sv/pgcb_back.sv =====
// Result serializer: while rsp_pop is high, emits one cell per cycle from the queue head particle.
module pgcb_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_not_empty,
   input  pgcb_pkg::pgcb_part_type        q_head,
   output logic                           q_pop,
   output logic                           retire,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [pgcb_pkg::IDX_W-1:0]     rsp_cell_index,
   output logic [1:0]                     rsp_corner,
   output logic                           rsp_last
);
   import pgcb_pkg::*;

   pgcb_part_type cur_ff, cur_in;
   logic          cur_valid_ff, cur_valid_in;
   logic [1:0]    step_ff, step_in;
   logic          is_last, fire, take;

   always_comb begin
      is_last      = step_ff == cur_ff.last_corner;
      fire         = rsp_pop && cur_valid_ff;
      retire       = fire && is_last;
      take         = !cur_valid_ff || retire;
      q_pop        = take && q_not_empty;
      cur_valid_in = take ? q_not_empty : cur_valid_ff;
      cur_in       = q_pop ? q_head : cur_ff;
      if (q_pop)
         step_in = CORNER_UL;
      else if (fire && !is_last)
         step_in = step_ff + 2'd1;
      else
         step_in = step_ff;
      rsp_empty      = !cur_valid_ff;
      rsp_cell_index = cur_ff.idx[step_ff];
      rsp_corner     = step_ff;
      rsp_last       = is_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= CORNER_UL;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
      end
      cur_ff <= cur_in;
   end

endmodule

// ===== sv/particle_grid_cell_binning.sv =====
// Top level of the uniform-grid cell binning block.
//
//  port group | direction | handshake            | payload
//  -----------+-----------+----------------------+----------------------------------------
//  req_       | in        | req_push / req_full  | center_x, center_y (s16 Q.4), radius (u13)
//  rsp_       | out       | rsp_empty / rsp_pop  | cell_index (24), corner (2), last (1)
//  csr_       | in        | csr_wr_en            | csr_index (2), csr_wdata (12)
//
// A request enters the front pipeline in any cycle without req_full; its cells reach the
// queue through the capture, divider, stride multiply and index add registers. The
// serializer sends one cell per cycle while rsp_pop is high and sets the sustained rate.
// req_full rises when 32 particles sit in the pipeline, queue and serializer together.
// Synchronous reset empties everything and loads the default area and cell size.
// A stalled result port holds its result; requests keep coming until req_full.
module particle_grid_cell_binning (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic signed [pgcb_pkg::COORD_W-1:0]   req_center_x,
   input  logic signed [pgcb_pkg::COORD_W-1:0]   req_center_y,
   input  logic        [pgcb_pkg::RADIUS_W-1:0]  req_radius,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic        [pgcb_pkg::IDX_W-1:0]     rsp_cell_index,
   output logic        [1:0]                     rsp_corner,
   output logic                                  rsp_last,
   input  logic                                  csr_wr_en,
   input  logic        [pgcb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [pgcb_pkg::REG_W-1:0]     csr_wdata
);
   import pgcb_pkg::*;

   // configuration registers
   logic [REG_W-1:0] area_width_ff, area_width_in;
   logic [REG_W-1:0] area_height_ff, area_height_in;
   logic [REG_W-1:0] cell_size_ff, cell_size_in;
   pgcb_cfg_type     cfg;

   always_comb begin
      area_width_in  = area_width_ff;
      area_height_in = area_height_ff;
      cell_size_in   = cell_size_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_AREA_WIDTH:  area_width_in  = csr_wdata;
            CSR_AREA_HEIGHT: area_height_in = csr_wdata;
            CSR_CELL_SIZE:   cell_size_in   = csr_wdata;
            default: ;   // drop writes to unknown registers
         endcase
      end
      cfg.area_width  = area_width_ff;
      cfg.area_height = area_height_ff;
      // treat a zero cell size as one pixel
      cfg.cell_size   = (cell_size_ff == '0) ? REG_W'(1) : cell_size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_width_ff  <= AREA_WIDTH_RST;
         area_height_ff <= AREA_HEIGHT_RST;
         cell_size_ff   <= CELL_SIZE_RST;
      end else begin
         area_width_ff  <= area_width_in;
         area_height_ff <= area_height_in;
         cell_size_ff   <= cell_size_in;
      end
   end

   // credits: count particles from acceptance until their last cell leaves,
   // so the queue can never overflow and the front never has to stall
   logic [QCNT_W-1:0] held_ff, held_in;
   logic              accept, retire;

   always_comb begin
      req_full = held_ff == QCNT_W'(QDEPTH);
      accept   = req_push && !req_full;
      held_in  = held_ff + QCNT_W'(accept) - QCNT_W'(retire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   logic          front_valid;
   pgcb_part_type front_part;
   logic          q_not_empty, q_pop;
   pgcb_part_type q_head;

   pgcb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (accept),
      .in_center_x (req_center_x),
      .in_center_y (req_center_y),
      .in_radius   (req_radius),
      .out_valid   (front_valid),
      .out_part    (front_part)
   );

   pgcb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_part (front_part),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_part (q_head)
   );

   pgcb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_not_empty    (q_not_empty),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .retire         (retire),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_cell_index (rsp_cell_index),
      .rsp_corner     (rsp_corner),
      .rsp_last       (rsp_last)
   );

endmodule

// ===== sv/pgcb_checker.sv =====
// Port-level checker for the grid cell binning block and its bind.
module pgcb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_push,
   input logic                              req_full,
   input logic                              rsp_empty,
   input logic                              rsp_pop,
   input logic [pgcb_pkg::IDX_W-1:0]        rsp_cell_index,
   input logic [1:0]                        rsp_corner,
   input logic                              rsp_last
);
   import pgcb_pkg::*;

   // a waiting result holds until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && $past(!rsp_empty && !rsp_pop)) |->
         (!rsp_empty && $stable(rsp_cell_index) && $stable(rsp_corner) && $stable(rsp_last)))
      else $error("result changed while stalled");

   // reset leaves an empty result side and room for requests
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("block not idle after reset");

   // the cell after upper-left is bottom-right, shown at once
   a_ul_then_br: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last && rsp_corner == CORNER_UL) |=>
         (!rsp_empty && rsp_corner == CORNER_BR))
      else $error("bottom-right did not follow upper-left");

   // the cell after a non-final bottom-right is upper-right
   a_br_then_ur: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && !rsp_last && rsp_corner == CORNER_BR) |=>
         (!rsp_empty && rsp_corner == CORNER_UR))
      else $error("upper-right did not follow bottom-right");

   // bottom-left always closes a particle, upper-right never does
   a_last_corner: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_corner != CORNER_BL || rsp_last) &&
                      (rsp_corner != CORNER_UR || !rsp_last)))
      else $error("wrong last flag for corner");

endmodule

bind particle_grid_cell_binning pgcb_checker u_pgcb_checker (.*);

// ===== verif/tb_particle_grid_cell_binning.sv =====
// Testbench for the uniform-grid cell binning block: directed, random and backpressure tests.
module tb_particle_grid_cell_binning;
   timeunit 1ns;
   timeprecision 1ps;

   import pgcb_pkg::*;

   // Index with no register behind it; writes there must leave the grid alone.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam int HOLD_CYCLES = 400;   // long receiver hold-off in the pressure test
   localparam int STALL_LIMIT = 2000;  // cycles without any handshake before giving up
   localparam int END_WAIT    = 40;    // pipeline latency plus margin at the end

   typedef struct packed {
      logic [IDX_W-1:0] cell_index;
      logic [1:0]       corner;
      logic             last;
   } cell_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_push = 1'b0;
   logic                        req_full;
   logic signed [COORD_W-1:0]   req_center_x = '0;
   logic signed [COORD_W-1:0]   req_center_y = '0;
   logic        [RADIUS_W-1:0]  req_radius = '0;
   logic                        rsp_empty;
   logic                        rsp_pop = 1'b0;
   logic        [IDX_W-1:0]     rsp_cell_index;
   logic        [1:0]           rsp_corner;
   logic                        rsp_last;
   logic                        csr_wr_en = 1'b0;
   logic        [CSR_IDX_W-1:0] csr_index = '0;
   logic        [REG_W-1:0]     csr_wdata = '0;

   // Shadow of the grid registers, tracked from the write port.
   logic [REG_W-1:0] grid_width  = AREA_WIDTH_RST;
   logic [REG_W-1:0] grid_height = AREA_HEIGHT_RST;
   logic [REG_W-1:0] grid_cell   = CELL_SIZE_RST;

   cell_result_type pending_cells[$];
   cell_result_type head_cell;
   int              mismatch_count = 0;
   int              stall_cycles = 0;

   // Sender burst control and receiver stall pattern.
   bit           req_steady = 1'b0;
   int           burst_left = 0;
   logic [15:0]  rsp_pattern = 16'hFFFF;
   logic [3:0]   pattern_pos = '0;
   bit           hold_rsp_request = 1'b0;

   particle_grid_cell_binning u_top (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_center_x   (req_center_x),
      .req_center_y   (req_center_y),
      .req_radius     (req_radius),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_cell_index (rsp_cell_index),
      .rsp_corner     (rsp_corner),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------

   // Map one Q.4 corner coordinate to a grid coordinate, clamped to [0, extent/cell].
   function automatic int grid_coord(int v, int extent);
      int cs;
      int top_cell;
      int limit;
      int c;
      cs       = (grid_cell == 0) ? 1 : int'(grid_cell);
      top_cell = extent / cs;
      limit    = extent << COORD_FRAC_BITS;
      if (v < 0)
         c = 0;
      else if (v > limit)
         c = top_cell;
      else begin
         c = v / (cs << COORD_FRAC_BITS);
         if (c > top_cell)
            c = top_cell;
      end
      return c;
   endfunction

   // Bucket index: column plus row times (cols + 1).
   function automatic logic [IDX_W-1:0] bucket_index(int x, int y);
      int cs;
      int cols;
      cs   = (grid_cell == 0) ? 1 : int'(grid_cell);
      cols = int'(grid_width) / cs;
      return IDX_W'(grid_coord(x, int'(grid_width)) +
                    grid_coord(y, int'(grid_height)) * (cols + 1));
   endfunction

   // Append one expected cell behind the ones already waiting.
   function automatic void queue_cell(cell_result_type c);
      pending_cells.insert(pending_cells.size(), c);
   endfunction

   // Queue the cells that one particle's bounding box touches, in emission order.
   function automatic void predict_cells(logic signed [COORD_W-1:0] px,
                                         logic signed [COORD_W-1:0] py,
                                         logic [RADIUS_W-1:0] rad);
      int cx;
      int cy;
      int r;
      logic [IDX_W-1:0] ul;
      logic [IDX_W-1:0] br;
      logic [IDX_W-1:0] ur;
      logic [IDX_W-1:0] bl;
      cx = px;
      cy = py;
      r  = int'(rad);
      ul = bucket_index(cx - r, cy - r);
      br = bucket_index(cx + r, cy + r);
      ur = bucket_index(cx + r, cy - r);
      bl = bucket_index(cx - r, cy + r);
      if (ul == br) begin
         queue_cell('{ul, CORNER_UL, 1'b1});
      end else if (ul != bl && ul != ur) begin
         queue_cell('{ul, CORNER_UL, 1'b0});
         queue_cell('{br, CORNER_BR, 1'b0});
         queue_cell('{ur, CORNER_UR, 1'b0});
         queue_cell('{bl, CORNER_BL, 1'b1});
      end else begin
         queue_cell('{ul, CORNER_UL, 1'b0});
         queue_cell('{br, CORNER_BR, 1'b1});
      end
   endfunction

   // ---------------------------------------------------------------------------------
   // Monitor: track register writes, predict accepted requests, check accepted results.
   // All sampling happens at the rising edge; inputs only move at the falling edge.
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         grid_width   = AREA_WIDTH_RST;
         grid_height  = AREA_HEIGHT_RST;
         grid_cell    = CELL_SIZE_RST;
         stall_cycles = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_AREA_WIDTH:  grid_width  = csr_wdata;
               CSR_AREA_HEIGHT: grid_height = csr_wdata;
               CSR_CELL_SIZE:   grid_cell   = csr_wdata;
               default: ;  // unmapped index: drop the write
            endcase
         end
         if (req_push && !req_full)
            predict_cells(req_center_x, req_center_y, req_radius);
         if (rsp_pop && !rsp_empty) begin
            if (pending_cells.size() == 0) begin
               $display({"%0t: unexpected result, expected none, ",
                         "got cell_index %0d corner %0d last %0d"},
                        $time, rsp_cell_index, rsp_corner, rsp_last);
               mismatch_count++;
            end else begin
               head_cell = pending_cells.pop_front();
               if (rsp_cell_index !== head_cell.cell_index) begin
                  $display("%0t: cell_index expected %0d got %0d",
                           $time, head_cell.cell_index, rsp_cell_index);
                  mismatch_count++;
               end
               if (rsp_corner !== head_cell.corner) begin
                  $display("%0t: corner expected %0d got %0d",
                           $time, head_cell.corner, rsp_corner);
                  mismatch_count++;
               end
               if (rsp_last !== head_cell.last) begin
                  $display("%0t: last expected %0d got %0d",
                           $time, head_cell.last, rsp_last);
                  mismatch_count++;
               end
            end
         end
         // Count cycles in which no handshake completes on either side.
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   // Watchdog: end the run if the block stops moving.
   initial begin
      while (stall_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   // Receiver: pop on a rotating stall pattern, or hold off for a long stretch on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_rsp_request) begin
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp_request = 1'b0;
         end else begin
            rsp_pop     = rsp_pattern[pattern_pos];
            pattern_pos = pattern_pos + 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------

   // Offer one request and return at the edge that accepts it. Push stays high on return
   // so back-to-back requests go out without a gap; wait_idle lowers it.
   task automatic send_particle(logic signed [COORD_W-1:0] px,
                                logic signed [COORD_W-1:0] py,
                                logic [RADIUS_W-1:0] rad);
      @(negedge clock);
      if (!req_steady) begin
         if (burst_left == 0) begin
            req_push = 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
      end
      req_push     = 1'b1;
      req_center_x = px;
      req_center_y = py;
      req_radius   = rad;
      do
         @(posedge clock);
      while (req_full);
   endtask

   // Random request shaped to the current grid: mostly near the area with radii around
   // the cell size, the rest anywhere in the field ranges.
   task automatic send_random_particle();
      int cs;
      int span_x;
      int span_y;
      int rmax;
      int cx;
      int cy;
      cs = (grid_cell == 0) ? 1 : int'(grid_cell);
      if ($urandom_range(9) < 7) begin
         span_x = (int'(grid_width) << COORD_FRAC_BITS) + 128;
         span_y = (int'(grid_height) << COORD_FRAC_BITS) + 128;
         if (span_x > 32767 + 64)
            span_x = 32767 + 64;
         if (span_y > 32767 + 64)
            span_y = 32767 + 64;
         rmax = (cs << COORD_FRAC_BITS) * 3 / 2;
         if (rmax > 8191)
            rmax = 8191;
         cx = int'($urandom_range(0, span_x)) - 64;
         cy = int'($urandom_range(0, span_y)) - 64;
         send_particle(COORD_W'(cx), COORD_W'(cy), RADIUS_W'($urandom_range(0, rmax)));
      end else begin
         send_particle(COORD_W'($urandom), COORD_W'($urandom), RADIUS_W'($urandom));
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [REG_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_grid(int w, int h, int cs);
      write_csr(CSR_AREA_WIDTH, REG_W'(w));
      write_csr(CSR_AREA_HEIGHT, REG_W'(h));
      write_csr(CSR_CELL_SIZE, REG_W'(cs));
   endtask

   // Drop push and wait until every predicted cell has been popped.
   task automatic wait_idle();
      @(negedge clock);
      req_push = 1'b0;
      while (pending_cells.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Reset grid (1024 x 768, cell 32): one, two and four cells, clamping at both ends,
   // coordinates exactly on and just past the area edge, field extremes.
   task automatic test_default_grid();
      rsp_pattern = 16'hFFFF;
      send_particle(16'sd1600, 16'sd1600, 13'd0);        // single cell
      send_particle(16'sd1536, 16'sd1600, 13'd16);       // straddles a column edge
      send_particle(16'sd1536, 16'sd1536, 13'd16);       // straddles both edges
      send_particle(16'sh8000, 16'sh8000, 13'd8191);     // all corners negative
      send_particle(16'sh7FFF, 16'sh7FFF, 13'd8191);     // all corners past the area
      send_particle(16'sh7FFF, 16'sh8000, 13'd0);
      send_particle(16'sh8000, 16'sh7FFF, 13'd8191);
      send_particle(16'sd16384, 16'sd12288, 13'd0);      // exactly on the far edge
      send_particle(16'sd16385, 16'sd12289, 13'd0);      // one step past it
      send_particle(16'sd16383, 16'sd12287, 13'd0);      // one step inside it
      send_particle(16'sd0, 16'sd0, 13'd0);
      send_particle(16'sd0, 16'sd0, 13'd8191);
      send_particle(16'sd8000, 16'sd6000, 13'd8191);
      wait_idle();
   endtask

   // Register extremes: cell size zero, widest grid, one cell, area below the cell size,
   // and a write to the unmapped index.
   task automatic test_grid_extremes();
      rsp_pattern = 16'h5555;
      set_grid(4095, 4095, 0);
      write_csr(CSR_UNMAPPED, 12'h005);
      send_particle(16'sd24, 16'sd24, 13'd8);
      send_particle(16'sh7FFF, 16'sh7FFF, 13'd0);
      send_particle(16'sh8000, 16'sh7FFF, 13'h1FFF);
      wait_idle();
      set_grid(4095, 4095, 4095);
      send_particle(16'sh7FFF, 16'sh7FFF, 13'd8191);
      send_particle(16'sd100, 16'sd100, 13'd50);
      wait_idle();
      set_grid(10, 5, 4095);
      send_particle(-16'sd100, 16'sd200, 13'd50);
      send_particle(16'sd80, 16'sd40, 13'd8191);
      wait_idle();
      set_grid(1, 1, 1);
      send_particle(16'sd8, 16'sd8, 13'd8);
      send_particle(16'sd16, 16'sd0, 13'd0);
      wait_idle();
   endtask

   // Random grids, random requests, random sender bursts and receiver stall patterns.
   task automatic test_random_grids();
      for (int phase = 0; phase < 6; phase++) begin
         case ($urandom_range(3))
            0: set_grid($urandom_range(1, 4095), $urandom_range(1, 4095),
                        $urandom_range(1, 64));
            1: set_grid($urandom_range(0, 4095), $urandom_range(0, 4095),
                        $urandom_range(0, 4095));
            2: set_grid(4095, 4095, $urandom_range(1, 16));
            default: set_grid($urandom_range(1, 300), $urandom_range(1, 300),
                              $urandom_range(1, 600));
         endcase
         case ($urandom_range(2))
            0: rsp_pattern = 16'hFFFF;
            1: rsp_pattern = 16'($urandom) | 16'h0001;
            default: rsp_pattern = 16'h0101;
         endcase
         req_steady = (phase % 3 == 0);
         repeat (62) send_random_particle();
         wait_idle();
      end
      req_steady = 1'b0;
   endtask

   // Hold the result side off long enough that the block fills and raises full while
   // requests keep coming back to back.
   task automatic test_result_backpressure();
      set_grid(1024, 768, 16);
      rsp_pattern      = 16'hFFFF;
      req_steady       = 1'b1;
      hold_rsp_request = 1'b1;
      repeat (48) send_random_particle();
      wait_idle();
      req_steady = 1'b0;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_default_grid();
      test_grid_extremes();
      test_random_grids();
      test_result_backpressure();
      wait_idle();
      // Give any stray result time to show up.
      repeat (END_WAIT) @(posedge clock);
      if (mismatch_count == 0 && pending_cells.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
